// ----- design/tab_pkg.sv -----
// ----------------------------------------------------------------------------
// tab_pkg: shared types and constants
// Widths, conversion constants, blink periods, result record and the small
// constant tables behind the block-average divider.
// ----------------------------------------------------------------------------
package tab_pkg;

  localparam int ADC_W   = 10;
  localparam int TEMP_W  = 8;
  localparam int BLINK_W = 13;
  localparam int SPER_W  = 14;
  localparam int ADC_MAX = (1 << ADC_W) - 1;

  // samples averaged per block while the alarm is raised
  localparam int BLOCK_SAMPLES = 6;
  localparam int CNT_W = $clog2(BLOCK_SAMPLES);
  localparam int SUM_W = $clog2(BLOCK_SAMPLES * ADC_MAX + 1);

  // divider split: sum = hi * 2**LO_W + lo
  localparam int LO_W  = 6;
  localparam int HI_W  = SUM_W - LO_W;
  localparam int IDX_W = LO_W + 1;

  // Q16 conversion: (adc * SLOPE - OFFSET) >> 16
  localparam int PROD_W = ADC_W + 15;
  localparam logic [14:0]       SLOPE_Q16  = 15'd27069;
  localparam logic [PROD_W-1:0] OFFSET_Q16 = PROD_W'(18202395);

  localparam logic [TEMP_W-1:0]  THRESH_RST = 8'd20;
  localparam logic [BLINK_W-1:0] PER_RST    = 13'd8191;  // 10999 saturated
  localparam logic [BLINK_W-1:0] PER_NRM_A  = 13'd7199;
  localparam logic [BLINK_W-1:0] PER_NRM_B  = 13'd4799;
  localparam logic [BLINK_W-1:0] PER_ALM_A  = 13'd2399;
  localparam logic [BLINK_W-1:0] PER_ALM_B  = 13'd3599;
  localparam logic [SPER_W-1:0]  SPER_NRM   = 14'd14000;
  localparam logic [SPER_W-1:0]  SPER_ALM   = 14'd4800;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic [SPER_W-1:0]  sample_period;
    logic [BLINK_W-1:0] blink_period;
    logic               led_second;
    logic               led_first;
    logic [TEMP_W-1:0]  temperature_c;
    logic               alarm_active;
  } res_t;

  typedef logic [2**HI_W-1:0][SUM_W-1:0]  qhi_tab_t;
  typedef logic [2**HI_W-1:0][CNT_W-1:0]  rhi_tab_t;
  typedef logic [2**IDX_W-1:0][IDX_W-1:0] qlo_tab_t;

  function automatic qhi_tab_t gen_qhi();
    qhi_tab_t t;
    for (int i = 0; i < 2**HI_W; i++) begin
      t[i] = SUM_W'((i << LO_W) / BLOCK_SAMPLES);
    end
    return t;
  endfunction

  function automatic rhi_tab_t gen_rhi();
    rhi_tab_t t;
    for (int i = 0; i < 2**HI_W; i++) begin
      t[i] = CNT_W'((i << LO_W) % BLOCK_SAMPLES);
    end
    return t;
  endfunction

  function automatic qlo_tab_t gen_qlo();
    qlo_tab_t t;
    for (int i = 0; i < 2**IDX_W; i++) begin
      t[i] = IDX_W'(i / BLOCK_SAMPLES);
    end
    return t;
  endfunction

  localparam qhi_tab_t QHI_TAB = gen_qhi();
  localparam rhi_tab_t RHI_TAB = gen_rhi();
  localparam qlo_tab_t QLO_TAB = gen_qlo();

endpackage

// ----- design/temperature_alarm_blinker.sv -----
// ----------------------------------------------------------------------------
// temperature_alarm_blinker: sensor alarm with LED blink pattern
// Converts ADC samples to degrees C, raises and clears an over-temperature
// alarm, and steps a two-phase LED pattern on each blink-timer tick.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  in_     | in  | tuser: command; tdata: adc_sample
//  out_    | out | tdata: alarm, temperature, LEDs, blink and sample periods
//  cfg_    | in  | cfg_data: alarm_threshold (always ready)
//
//  One beat per clock sustained while the result register is drained. An
//  input beat is captured in the input register at the accepting edge;
//  once the result register is free it passes through the converter, the
//  block divider and the state update into the result register, which
//  drives out_tvalid. Synchronous active-low reset; threshold resets to
//  20 C, blink period to 8191. A stalled result holds both registers; the
//  input register still takes a beat while the result register is full but
//  being drained.
// ----------------------------------------------------------------------------
module temperature_alarm_blinker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] adc_sample, [15:10] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] alarm_active, [8:1] temperature_c,
                                  // [9] led_first, [10] led_second,
                                  // [23:11] blink_period, [37:24] sample_period,
                                  // [39:38] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tab_pkg::*;

  logic              s1_vld_r;
  logic              s1_cmd_r;
  logic [ADC_W-1:0]  s1_adc_r;
  logic              out_vld_r;
  res_t              out_r;
  logic [TEMP_W-1:0] thresh_r;
  res_t              res;
  logic              out_load;
  logic              in_load;

  // result register frees when empty or drained this cycle
  assign out_load  = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || out_load;
  assign in_load   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_cmd_r <= in_tuser;
      s1_adc_r <= in_tdata[ADC_W-1:0];
    end
  end

  tab_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (out_load),
    .cmd       (s1_cmd_r),
    .adc       (s1_adc_r),
    .threshold (thresh_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r};

  // sample period follows the alarm flag
  a_sper: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] ? (out_tdata[37:24] == SPER_ALM)
                                 : (out_tdata[37:24] == SPER_NRM)))
    else $error("sample period disagrees with alarm state");

  // LED pattern and blink period come from the same phase
  a_blink: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tdata[10:9] == 2'b01) && (out_tdata[23:11] == PER_NRM_A)) ||
      ((out_tdata[10:9] == 2'b10) && (out_tdata[23:11] == PER_NRM_B)) ||
      ((out_tdata[10:9] == 2'b11) && (out_tdata[23:11] == PER_ALM_A)) ||
      ((out_tdata[10:9] == 2'b00) && (out_tdata[23:11] == PER_ALM_B)) ||
      ((out_tdata[10:9] == 2'b00) && (out_tdata[23:11] == PER_RST)))
    else $error("LED drive and blink period out of step");

  // a held input beat only ever waits on a full, stalled result register
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && out_vld_r && !out_tready))
    else $error("input stalled without downstream backpressure");

  // an accepted beat always sits in the input register the cycle after it is taken
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_load |=> s1_vld_r)
    else $error("accepted beat lost from input register");

endmodule

// ----- design/tab_avg.sv -----
// ----------------------------------------------------------------------------
// tab_avg: block average
// Integer sum / BLOCK_SAMPLES by three table lookups and two adds.
// ----------------------------------------------------------------------------
module tab_avg (
  input  logic [tab_pkg::SUM_W-1:0] sum,
  output logic [tab_pkg::ADC_W-1:0] avg
);
  import tab_pkg::*;

  logic [HI_W-1:0]  hi;
  logic [LO_W-1:0]  lo;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] quo;

  assign hi  = sum[SUM_W-1:LO_W];
  assign lo  = sum[LO_W-1:0];
  // remainder of the high part folds into the low part
  assign idx = {1'b0, lo} + IDX_W'(RHI_TAB[hi]);
  assign quo = QHI_TAB[hi] + SUM_W'(QLO_TAB[idx]);
  // a full block never exceeds BLOCK_SAMPLES * ADC_MAX
  assign avg = quo[ADC_W-1:0];

endmodule

// ----- design/tab_celsius.sv -----
// ----------------------------------------------------------------------------
// tab_celsius: ADC code to degrees C
// Q16 slope and offset, clamped at zero, saturated at full scale.
// ----------------------------------------------------------------------------
module tab_celsius (
  input  logic [tab_pkg::ADC_W-1:0]  adc,
  output logic [tab_pkg::TEMP_W-1:0] temp
);
  import tab_pkg::*;

  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    diff;
  logic [PROD_W-17:0]   whole;

  assign prod  = PROD_W'(adc) * PROD_W'(SLOPE_Q16);
  assign diff  = prod - OFFSET_Q16;
  assign whole = diff[PROD_W-1:16];

  always_comb begin
    if (prod <= OFFSET_Q16) begin
      temp = '0;
    end else if (whole > (PROD_W-16)'({TEMP_W{1'b1}})) begin
      temp = '1;
    end else begin
      temp = whole[TEMP_W-1:0];
    end
  end

endmodule

// ----- design/tab_core.sv -----
// ----------------------------------------------------------------------------
// tab_core: alarm and blink state
// Holds the block state and works out the next state and the result for
// one item in a single pass.
// ----------------------------------------------------------------------------
module tab_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       cmd,
  input  logic [tab_pkg::ADC_W-1:0]  adc,
  input  logic [tab_pkg::TEMP_W-1:0] threshold,
  output tab_pkg::res_t              res
);
  import tab_pkg::*;

  logic               alarm_r, alarm_nxt;
  logic               phase_r, phase_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TEMP_W-1:0]  temp_r, temp_nxt;
  logic [1:0]         led_r, led_nxt;
  logic [BLINK_W-1:0] per_r, per_nxt;

  logic [SUM_W-1:0]   sum_add;
  logic [ADC_W-1:0]   avg;
  logic [ADC_W-1:0]   conv_in;
  logic [TEMP_W-1:0]  conv_t;

  assign sum_add = sum_r + SUM_W'(adc);
  assign conv_in = alarm_r ? avg : adc;

  tab_avg u_avg (
    .sum (sum_add),
    .avg (avg)
  );

  tab_celsius u_cel (
    .adc  (conv_in),
    .temp (conv_t)
  );

  always_comb begin
    alarm_nxt = alarm_r;
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    temp_nxt  = temp_r;
    led_nxt   = led_r;
    per_nxt   = per_r;
    case (cmd)
      CMD_SAMPLE: begin
        if (!alarm_r) begin
          temp_nxt = conv_t;
          if (conv_t > threshold) begin
            alarm_nxt = 1'b1;
            sum_nxt   = '0;
            cnt_nxt   = '0;
          end
        end else if (cnt_r == CNT_W'(BLOCK_SAMPLES - 1)) begin
          temp_nxt = conv_t;
          sum_nxt  = '0;
          cnt_nxt  = '0;
          if (conv_t < threshold) begin
            alarm_nxt = 1'b0;
          end
        end else begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_TICK: begin
        phase_nxt = ~phase_r;
        case ({alarm_r, phase_r})
          2'b00:   begin led_nxt = 2'b01; per_nxt = PER_NRM_A; end
          2'b01:   begin led_nxt = 2'b10; per_nxt = PER_NRM_B; end
          2'b10:   begin led_nxt = 2'b11; per_nxt = PER_ALM_A; end
          default: begin led_nxt = 2'b00; per_nxt = PER_ALM_B; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= 1'b0;
      phase_r <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
      temp_r  <= '0;
      led_r   <= 2'b00;
      per_r   <= PER_RST;
    end else if (advance) begin
      alarm_r <= alarm_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      temp_r  <= temp_nxt;
      led_r   <= led_nxt;
      per_r   <= per_nxt;
    end
  end

  always_comb begin
    res.alarm_active  = alarm_nxt;
    res.temperature_c = temp_nxt;
    res.led_first     = led_nxt[0];
    res.led_second    = led_nxt[1];
    res.blink_period  = per_nxt;
    res.sample_period = alarm_nxt ? SPER_ALM : SPER_NRM;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: temperature_alarm_blinker testbench
// Drives sample and tick beats over the input stream and writes the alarm
// threshold between phases. A behavioural predictor builds the expected status
// beat for every accepted input, and each output beat is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import tab_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_BEATS = 60;

  // --------------------------------------------------------------------------
  // Status predictor and store of expected output beats
  // --------------------------------------------------------------------------
  class alarm_status_board;
    logic [7:0]  threshold;
    logic        alarm;
    logic        blink_ph;
    logic [12:0] block_sum;
    logic [2:0]  block_cnt;
    logic [7:0]  temp;
    logic [1:0]  leds;
    logic [12:0] period;
    res_t        status_q[$];
    int          errors;

    function new();
      threshold = 8'd20;
      alarm     = 1'b0;
      blink_ph  = 1'b0;
      block_sum = '0;
      block_cnt = '0;
      temp      = '0;
      leds      = 2'b00;
      period    = 13'd8191;   // 10999 does not fit, saturates
      errors    = 0;
    endfunction

    // Q16 linear fit, clamped at 0 and 255
    static function logic [7:0] adc_to_degc(logic [9:0] adc);
      logic [24:0] prod;
      logic [24:0] diff;
      prod = 25'(adc) * 25'd27069;
      if (prod <= 25'd18202395) return 8'd0;
      diff = (prod - 25'd18202395) >> 16;
      return (diff > 25'd255) ? 8'd255 : diff[7:0];
    endfunction

    // advance the state for one accepted input beat, queue its status beat
    function void apply_beat(logic cmd, logic [9:0] adc);
      res_t r;
      if (cmd == CMD_SAMPLE) begin
        if (!alarm) begin
          temp = adc_to_degc(adc);
          if (temp > threshold) begin
            alarm     = 1'b1;
            block_sum = '0;
            block_cnt = '0;
          end
        end else begin
          block_sum = block_sum + 13'(adc);
          if (int'(block_cnt) + 1 >= BLOCK_SAMPLES) begin
            temp      = adc_to_degc(10'(block_sum / 13'(BLOCK_SAMPLES)));
            block_sum = '0;
            block_cnt = '0;
            if (temp < threshold) alarm = 1'b0;
          end else begin
            block_cnt = block_cnt + 3'd1;
          end
        end
      end else begin
        case ({alarm, blink_ph})
          2'b00: begin leds = 2'b01; period = 13'd7199; end
          2'b01: begin leds = 2'b10; period = 13'd4799; end
          2'b10: begin leds = 2'b11; period = 13'd2399; end
          default: begin leds = 2'b00; period = 13'd3599; end
        endcase
        blink_ph = ~blink_ph;
      end
      r.alarm_active  = alarm;
      r.temperature_c = temp;
      r.led_first     = leds[0];
      r.led_second    = leds[1];
      r.blink_period  = period;
      r.sample_period = alarm ? 14'd4800 : 14'd14000;
      status_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [13:0] want, logic [13:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_status(logic [39:0] data);
      res_t got;
      res_t want;
      got = res_t'(data[37:0]);
      if (status_q.size() == 0) begin
        errors++;
        $error("status beat with nothing expected: %h", data);
        return;
      end
      want = status_q.pop_front();
      cmp_field("alarm_active",  14'(want.alarm_active),  14'(got.alarm_active));
      cmp_field("temperature_c", 14'(want.temperature_c), 14'(got.temperature_c));
      cmp_field("led_first",     14'(want.led_first),     14'(got.led_first));
      cmp_field("led_second",    14'(want.led_second),    14'(got.led_second));
      cmp_field("blink_period",  14'(want.blink_period),  14'(got.blink_period));
      cmp_field("sample_period", 14'(want.sample_period), 14'(got.sample_period));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [9:0] adc_sample, [15:10] zero
  logic        in_tuser   = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [0] alarm, [8:1] temp, [9] led0, [10] led1,
                                  // [23:11] blink period, [37:24] sample period
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // idle control: calm = no gaps on that side; hold request for the sink
  bit tx_calm      = 1'b0;
  bit rx_calm      = 1'b0;
  bit rx_hold_want = 1'b0;

  alarm_status_board sb;

  always #5 clk = ~clk;

  temperature_alarm_blinker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Sink: random back-pressure, plus one long hold-off counted here so the
  // pipeline fills and in_tready drops while the source keeps offering.
  // --------------------------------------------------------------------------
  int  rx_hold_left = 0;
  bit  rx_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rx_hold_want && !rx_hold_done) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_done = 1'b1;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // output monitor: values seen here are the ones before this edge's updates
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Source side tasks
  // --------------------------------------------------------------------------

  // one input beat; random gaps in front unless calm
  task automatic send_beat(input logic cmd, input logic [9:0] adc);
    if (!tx_calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, adc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_beat(cmd, adc);
  endtask

  // called at the edge of the last accept, so in_tvalid gets one update only
  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic tick();
    send_beat(CMD_TICK, 10'($urandom));
  endtask

  task automatic sample(input logic [9:0] adc, input int n);
    repeat (n) send_beat(CMD_SAMPLE, adc);
  endtask

  // all status beats in, then let the two-stage pipe settle
  task automatic wait_drained();
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] thr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.threshold = thr;
  endtask

  // random beats in runs of eight with a common temperature flavour, so the
  // alarm gets raised and blocks of six average both above and below it
  task automatic send_random(input int n);
    int          flavour;
    int          centre;
    logic [9:0]  adc;
    flavour = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 8 == 0) flavour = $urandom_range(3);
      if ($urandom_range(99) < 25) begin
        tick();
      end else begin
        case (flavour)
          0: adc = 10'($urandom);
          1: adc = 10'($urandom_range(1023, 820));
          2: adc = 10'($urandom_range(690, 0));
          default: begin
            // about 2.42 codes per degree above the zero crossing at 672
            centre = 672 + (int'(sb.threshold) * 242) / 100
                     + int'($urandom_range(16)) - 8;
            if (centre > 1023) centre = 1023;
            adc = 10'(centre);
          end
        endcase
        send_beat(CMD_SAMPLE, adc);
      end
    end
    end_burst();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset threshold, 723 -> 20 C (not above), 724 -> 21 C
    write_threshold(8'd20);
    tick();                     // normal, first LED
    tick();                     // normal, second LED
    sample(10'd723, 1);
    sample(10'd724, 1);         // alarm raised, block emptied
    tick();                     // alarm, both on
    tick();                     // alarm, both off
    sample(10'd1023, 2);        // partial block, temperature repeats
    tick();                     // tick mid-block
    sample(10'd1023, 4);        // block complete at 144 C, alarm stays
    sample(10'd723, 6);         // average exactly at threshold, stays
    sample(10'd0, 6);           // average 0 C, alarm clears
    end_burst();

    // threshold 0: any warm sample raises, nothing can clear
    write_threshold(8'd0);
    send_random(PHASE_BEATS);

    // threshold 255: never raised
    write_threshold(8'd255);
    send_random(PHASE_BEATS);

    // no gaps on either side
    write_threshold(8'($urandom_range(144)));
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_random(PHASE_BEATS);
    rx_calm = 1'b0;

    // sink holds off while the source streams
    write_threshold(8'($urandom_range(144)));
    rx_hold_want = 1'b1;
    send_random(PHASE_BEATS);
    tx_calm = 1'b0;

    repeat (3) begin
      write_threshold(8'($urandom_range(60, 10)));
      send_random(PHASE_BEATS);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
